// ===== sv/pmu_pkg.sv =====
// ----------------------------------------------------------------------------
// pmu_pkg: shared constants and types of the polynomial multiply unit
// default sizes and the control word that steers each convolution cell
// ----------------------------------------------------------------------------
package pmu_pkg;

  localparam int unsigned MaxDegreeDefault  = 15;
  localparam int unsigned CoeffWidthDefault = 32;

  // tuser code: which operand a coefficient belongs to
  localparam logic KindFirst  = 1'b0;
  localparam logic KindSecond = 1'b1;

  // per-cell control for one clock
  typedef struct packed {
    logic step;      // take the neighbour's sum as the new partial sum
    logic clr_sum;   // clear the partial sum
    logic coef_clr;  // clear the held coefficient
    logic coef_we;   // write the held coefficient (wins over coef_clr)
  } cell_ctrl_t;

endpackage

// ===== sv/pmu_cell.sv =====
// ----------------------------------------------------------------------------
// pmu_cell: one cell of the transposed convolution chain
// holds one first-operand coefficient and one partial sum; hands its
// updated sum to the lower neighbour
// ----------------------------------------------------------------------------
module pmu_cell #(
  parameter int unsigned COEFF_WIDTH = pmu_pkg::CoeffWidthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  pmu_pkg::cell_ctrl_t    ctrl_i,
  input  logic [COEFF_WIDTH-1:0] coeff_i,  // load data
  input  logic [COEFF_WIDTH-1:0] mult_i,   // second-operand multiplicand
  input  logic [COEFF_WIDTH-1:0] sum_i,    // from the upper neighbour
  output logic [COEFF_WIDTH-1:0] sum_o     // to the lower neighbour
);

  logic [COEFF_WIDTH-1:0] coef_q, coef_d;
  logic [COEFF_WIDTH-1:0] psum_q, psum_d;

  // wraps modulo 2^COEFF_WIDTH
  assign sum_o = psum_q + coef_q * mult_i;

  always_comb begin
    coef_d = coef_q;
    if (ctrl_i.coef_we) begin
      coef_d = coeff_i;
    end else if (ctrl_i.coef_clr) begin
      coef_d = '0;
    end
  end

  always_comb begin
    psum_d = psum_q;
    if (ctrl_i.clr_sum) begin
      psum_d = '0;
    end else if (ctrl_i.step) begin
      psum_d = sum_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
      psum_q <= '0;
    end else begin
      coef_q <= coef_d;
      psum_q <= psum_d;
    end
  end

endmodule

// ===== sv/polynomial_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply_unit: integer polynomial product by linear convolution
// a row of multiply-accumulate cells forms a transposed convolution chain
// ----------------------------------------------------------------------------
// usage
//   slave stream: tdata carries one coefficient, tuser the operand kind
//   (0 first operand, 1 second operand), tlast the highest-degree one.
//   first-operand words load the held polynomial, lowest degree first, up
//   to MAX_DEGREE+1 words; extra words are dropped. they give no output.
//   second-operand words each give one product word in the cycle after
//   acceptance, one word per cycle while the master side keeps up.
//   the last second-operand word is followed by count-1 tail words (count
//   = number of held coefficients), one a cycle while the master side keeps
//   up; the slave side is held off (tready low) until the last tail word is
//   registered. master tlast marks the final product word.
//   a stalled master holds the registered word; the chain does not advance
//   and the slave side deasserts tready until the word is taken.
//   reset loads the zero polynomial of degree 0 and clears all sums; no
//   clearing pass is needed.
// ----------------------------------------------------------------------------
module polynomial_multiply_unit #(
  parameter int unsigned MAX_DEGREE  = pmu_pkg::MaxDegreeDefault,
  parameter int unsigned COEFF_WIDTH = pmu_pkg::CoeffWidthDefault,
  localparam int unsigned DATA_W     = ((COEFF_WIDTH + 7) / 8) * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [DATA_W-1:0] s_axis_tdata_i,   // coeff
  input  logic              s_axis_tuser_i,   // kind
  input  logic              s_axis_tlast_i,   // last
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [DATA_W-1:0] m_axis_tdata_o,   // product
  output logic              m_axis_tlast_o    // last_res
);

  localparam int unsigned NCOEF = MAX_DEGREE + 1;
  localparam int unsigned CNT_W = $clog2(NCOEF + 1);

  // control state
  logic             loading_q, loading_d;
  logic [CNT_W-1:0] count_q, count_d;      // held coefficients, 1..NCOEF
  logic [CNT_W-1:0] flush_q, flush_d;      // tail words still to send

  // output register
  logic                   out_valid_q, out_valid_d;
  logic                   out_last_q, out_last_d;
  logic [COEFF_WIDTH-1:0] out_prod_q, out_prod_d;

  logic                   in_acc;
  logic                   out_free;
  logic                   load_word;
  logic                   mul_word;
  logic                   flush_step;
  logic                   step;
  logic                   load_start;
  logic [COEFF_WIDTH-1:0] coeff;
  logic [COEFF_WIDTH-1:0] mult;

  // sums flowing down the chain; the top entry feeds zeros in
  logic [COEFF_WIDTH-1:0] chain_sum [NCOEF+1];

  assign coeff      = s_axis_tdata_i[COEFF_WIDTH-1:0];
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = out_free && (flush_q == '0);
  assign in_acc     = s_axis_tvalid_i && s_axis_tready_o;
  assign load_word  = in_acc && (s_axis_tuser_i == pmu_pkg::KindFirst);
  assign mul_word   = in_acc && (s_axis_tuser_i == pmu_pkg::KindSecond);
  assign flush_step = out_free && (flush_q != '0);
  assign step       = mul_word || flush_step;
  assign load_start = load_word && !loading_q;
  // tail flush shifts the chain with a zero multiplicand
  assign mult       = mul_word ? coeff : '0;

  assign chain_sum[NCOEF] = '0;

  // the cell row
  for (genvar i = 0; i < NCOEF; i++) begin : g_cell
    pmu_pkg::cell_ctrl_t ctrl;

    always_comb begin
      ctrl.step     = step;
      ctrl.clr_sum  = load_word;
      ctrl.coef_clr = load_start;
      // a fresh load writes cell 0, a running one writes the next free cell
      ctrl.coef_we  = load_word && (load_start ? (i == 0) : (count_q == CNT_W'(i)));
    end

    pmu_cell #(
      .COEFF_WIDTH (COEFF_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .coeff_i (coeff),
      .mult_i  (mult),
      .sum_i   (chain_sum[i+1]),
      .sum_o   (chain_sum[i])
    );
  end

  // load bookkeeping and tail counter
  always_comb begin
    loading_d = loading_q;
    count_d   = count_q;
    flush_d   = flush_q;
    if (load_word) begin
      loading_d = !s_axis_tlast_i;
      if (load_start) begin
        count_d = CNT_W'(1);
      end else if (count_q < CNT_W'(NCOEF)) begin
        count_d = count_q + CNT_W'(1);
      end
    end else if (mul_word) begin
      loading_d = 1'b0;
      if (s_axis_tlast_i) begin
        flush_d = count_q - CNT_W'(1);
      end
    end else if (flush_step) begin
      flush_d = flush_q - CNT_W'(1);
    end
  end

  // output word: lowest finished product coefficient
  always_comb begin
    out_valid_d = out_valid_q;
    out_last_d  = out_last_q;
    out_prod_d  = out_prod_q;
    if (step) begin
      out_valid_d = 1'b1;
      out_prod_d  = chain_sum[0];
      out_last_d  = mul_word ? (s_axis_tlast_i && (count_q == CNT_W'(1)))
                             : (flush_q == CNT_W'(1));
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loading_q   <= 1'b0;
      count_q     <= CNT_W'(1);
      flush_q     <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      loading_q   <= loading_d;
      count_q     <= count_d;
      flush_q     <= flush_d;
      out_valid_q <= out_valid_d;
      out_last_q  <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_prod_q <= out_prod_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = DATA_W'(out_prod_q);

`ifndef SYNTHESIS
  // the held polynomial always has between one and NCOEF coefficients
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0) && (count_q <= CNT_W'(NCOEF)))
    else $error("held coefficient count out of range");

  // the final product word leaves no tail behind it
  a_last_no_tail : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (flush_q == '0))
    else $error("final product word with tail words pending");

  // a tail flush never overlaps a first-operand load
  a_load_no_flush : assert property (@(posedge clk_i) disable iff (!rst_ni)
    loading_q |-> (flush_q == '0))
    else $error("tail flush during operand load");

  // a tail step always produces a word on the next cycle
  a_flush_emits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_step |=> m_axis_tvalid_o)
    else $error("tail step without an output word");
`endif

endmodule

// ===== test/polynomial_multiply_unit_tb.sv =====
// ----------------------------------------------------------------------------
// polynomial_multiply_unit_tb: self-checking bench for the polynomial multiply unit
// streams first- and second-operand words through the slave side, predicts
// every product word and compares it with what leaves the master side, with
// random gaps on both sides and three back-pressure regimes
// ----------------------------------------------------------------------------
module polynomial_multiply_unit_tb;

  localparam int unsigned NCoef      = pmu_pkg::MaxDegreeDefault + 1;
  localparam int unsigned CoeffW     = pmu_pkg::CoeffWidthDefault;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [CoeffW-1:0] product;
    logic              last;
  } prod_word_t;

  // convolution predictor and queue of product words still to come
  class ProductScoreboard;
    logic [CoeffW-1:0] held_coeff [NCoef];
    logic [CoeffW-1:0] run_sum    [NCoef];
    int unsigned       held_count = 1;
    bit                loading    = 1'b0;
    prod_word_t        pending_products [$];
    int unsigned       errors, first_words, second_words, products_seen;

    function void clear_sums();
      foreach (run_sum[i]) run_sum[i] = '0;
    endfunction

    function void clear_all();
      foreach (held_coeff[i]) held_coeff[i] = '0;
      clear_sums();
    endfunction

    function int unsigned pending();
      return pending_products.size();
    endfunction

    task report(string msg);
      if (errors < 30) $display("%0t mismatch: %s", $realtime, msg);
      errors++;
    endtask

    function void note_coeff(logic kind, logic [CoeffW-1:0] coeff, logic last);
      logic [CoeffW-1:0] fresh [NCoef];
      int unsigned       taps;
      prod_word_t        w;
      if (kind == pmu_pkg::KindFirst) begin
        first_words++;
        if (!loading) begin
          foreach (held_coeff[i]) held_coeff[i] = '0;
          held_count = 0;
          loading    = 1'b1;
        end
        clear_sums();
        // words beyond the coefficient store are dropped
        if (held_count < NCoef) begin
          held_coeff[held_count] = coeff;
          held_count++;
        end
        if (last) loading = 1'b0;
        return;
      end
      second_words++;
      loading = 1'b0;
      taps    = (held_count < 1) ? 1 : held_count;
      for (int unsigned i = 0; i < taps; i++)
        fresh[i] = run_sum[i] + held_coeff[i] * coeff;
      w.product = fresh[0];
      w.last    = last && (taps == 1);
      pending_products.push_back(w);
      for (int unsigned i = 0; i + 1 < taps; i++) run_sum[i] = fresh[i + 1];
      run_sum[taps-1] = '0;
      if (last) begin
        // tail flush of the remaining partial sums
        for (int unsigned i = 0; i + 1 < taps; i++) begin
          w.product = run_sum[i];
          w.last    = (i + 2 == taps);
          pending_products.push_back(w);
        end
        clear_sums();
      end
    endfunction

    task check_word(logic [CoeffW-1:0] product, logic last);
      prod_word_t w;
      products_seen++;
      if (pending_products.size() == 0) begin
        report($sformatf("unexpected product word %h last %b", product, last));
        return;
      end
      w = pending_products.pop_front();
      if (product !== w.product)
        report($sformatf("product %h, expected %h", product, w.product));
      if (last !== w.last)
        report($sformatf("last %b, expected %b (product %h)", last, w.last, w.product));
    endtask
  endclass

  logic              clk_i    = 1'b0;
  logic              rst_ni   = 1'b0;
  logic              s_tvalid = 1'b0;
  logic [CoeffW-1:0] s_tdata  = '0;
  logic              s_tuser  = pmu_pkg::KindFirst;
  logic              s_tlast  = 1'b0;
  logic              m_tready = 1'b0;
  logic              s_axis_tready_o;
  logic              m_axis_tvalid_o;
  logic [CoeffW-1:0] m_axis_tdata_o;
  logic              m_axis_tlast_o;

  ProductScoreboard sb = new;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_counted = 0;
  int unsigned cycle_count   = 0;

  polynomial_multiply_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),    // coeff
    .s_axis_tuser_i  (s_tuser),    // kind
    .s_axis_tlast_i  (s_tlast),    // last
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // product
    .m_axis_tlast_o  (m_axis_tlast_o)   // last_res
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_word(m_axis_tdata_o, m_axis_tlast_o);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d product words outstanding",
               cycle_count, sb.pending());
      $display("polynomial_multiply_unit_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [CoeffW-1:0] rand_coeff();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return $urandom_range(20) - 10;
      default: return $urandom;
    endcase
  endfunction

  // one slave-side word, with random gaps before it; counted unless dropped
  task automatic send_word(logic kind, logic [CoeffW-1:0] coeff, logic last,
                           bit counted = 1'b1);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= coeff;
    s_tuser  <= kind;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_coeff(kind, coeff, last);
    if (counted) words_counted++;
  endtask

  task automatic load_first(int unsigned n, bit terminate);
    for (int unsigned i = 0; i < n; i++)
      send_word(pmu_pkg::KindFirst, rand_coeff(), terminate && (i == n - 1), i < NCoef);
  endtask

  task automatic stream_second(int unsigned n, bit terminate);
    for (int unsigned i = 0; i < n; i++)
      send_word(pmu_pkg::KindSecond, rand_coeff(), terminate && (i == n - 1));
  endtask

  // hold the sender off until every predicted product word has arrived
  task automatic drain_products();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  task automatic run_random(int unsigned target);
    int unsigned start;
    int unsigned pick;
    start = words_counted;
    while (words_counted - start < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        // well-formed product: mostly short operands, now and then a long one
        load_first(($urandom_range(9) == 0) ? $urandom_range(9, NCoef)
                                            : $urandom_range(1, 6), 1'b1);
        repeat ($urandom_range(1, 3)) stream_second($urandom_range(1, 6), 1'b1);
      end else if (pick < 85) begin
        load_first($urandom_range(NCoef + 1, NCoef + 4), 1'b1);
        stream_second($urandom_range(1, 3), 1'b1);
      end else if (pick < 93) begin
        // load left open, closed by the second operand
        load_first($urandom_range(1, 5), 1'b0);
        stream_second($urandom_range(1, 4), 1'b1);
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(1'($urandom_range(1)), rand_coeff(), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    // predictor starts from the reset state: zero polynomial, clear sums
    sb.clear_all();
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 25;
    recv_idle_pct = 60;

    // zero polynomial straight after reset: one word, flagged last
    send_word(pmu_pkg::KindSecond, 32'h7fff_ffff, 1'b1);
    // extreme values, wrapping products
    send_word(pmu_pkg::KindFirst, 32'h7fff_ffff, 1'b0);
    send_word(pmu_pkg::KindFirst, 32'h8000_0000, 1'b1);
    send_word(pmu_pkg::KindSecond, 32'h8000_0000, 1'b0);
    send_word(pmu_pkg::KindSecond, 32'hffff_ffff, 1'b1);
    // degree-0 first operand
    send_word(pmu_pkg::KindFirst, 32'hffff_ffff, 1'b1);
    send_word(pmu_pkg::KindSecond, 32'h8000_0000, 1'b1);
    // overlong load, extras dropped, then the longest tail
    for (int unsigned i = 0; i < NCoef + 2; i++)
      send_word(pmu_pkg::KindFirst, (i % 2 == 0) ? 32'h8000_0000 : 32'hffff_ffff,
                i == NCoef + 1, i < NCoef);
    send_word(pmu_pkg::KindSecond, 32'h7fff_ffff, 1'b1);
    // load without a last marker, ended by the second operand
    send_word(pmu_pkg::KindFirst, 32'h0000_0000, 1'b0);
    send_word(pmu_pkg::KindSecond, 32'hffff_ffff, 1'b1);
    drain_products();

    run_random(100);
    drain_products();

    send_idle_pct = 60;
    recv_idle_pct = 25;
    run_random(95);
    drain_products();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(95);
    drain_products();

    // room for any stray word after the longest tail
    repeat (NCoef + 8) @(negedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d product words never arrived", sb.pending()));

    $display("run covered %0d first-operand and %0d second-operand words, %0d product words",
             sb.first_words, sb.second_words, sb.products_seen);
    $display("under sender-heavy, receiver-heavy and gap-free handshakes; %0d mismatches",
             sb.errors);
    if (sb.errors == 0)
      $display("polynomial_multiply_unit_tb: done, clean");
    else
      $display("polynomial_multiply_unit_tb: done, errors");
    $finish;
  end

endmodule
